>>> src/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sti_pkg.sv
package sti_pkg;

  localparam int DEPTH     = 32;
  localparam int MAX_OUT   = 32;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_IDX_W = 5;
  localparam int OUT_POS_W = 6;
  localparam int OUT_N     = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    shift;  // this cell moves up on insert
    logic                    valid;
  } cell_link_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic busy;
    logic load;
  } ctrl_t;

endpackage

>>> src/sti_cell.sv
module sti_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 ins,
  input  logic signed [sti_pkg::VAL_W-1:0]     new_value,
  input  sti_pkg::cell_link_t                  left,
  output sti_pkg::cell_link_t                  link,
  output logic                                 mark
);

  logic signed [sti_pkg::VAL_W-1:0] val;
  logic                             valid;
  logic                             shift;

  // Empty cells act as +infinity, so the new value lands at the first one.
  assign shift = !valid || (new_value < val);
  assign mark  = left.valid && !left.shift && shift;

  assign link.val   = val;
  assign link.shift = shift;
  assign link.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      valid <= valid || left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && shift) begin
      val <= left.shift ? left.val : new_value;
    end
  end

endmodule

>>> src/sorted_table_insert.sv
// Sorted table of signed 32-bit values held in a row of cells, one entry per
// cell. An insert (start high while busy low) is compared against every cell
// at once and the cells above the insertion point move up one place in that
// same cycle. The table is then read out in ascending order, one result per
// cycle on result_strobe, is_last on the final one; there is one result for
// each entry held after the insert, at most 32. The last result shows in the
// cycle busy drops, so the next start can be taken then.
// Results cannot be held off: the receiver must take each one when strobed.
// A full table drops the value and reads out with rejected set.
module sorted_table_insert (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sti_pkg::VAL_W-1:0]      new_value,
  output logic                                  result_strobe,
  output logic signed [sti_pkg::VAL_W-1:0]      entry_value,
  output logic        [sti_pkg::OUT_IDX_W-1:0]  entry_index,
  output logic        [sti_pkg::OUT_POS_W-1:0]  inserted_at,
  output logic                                  rejected,
  output logic                                  is_last
);

  localparam sti_pkg::cell_link_t BOUNDARY = '{val: '0, shift: 1'b0, valid: 1'b1};

  sti_pkg::cell_link_t              cell_out [sti_pkg::DEPTH];
  logic [sti_pkg::DEPTH-1:0]        marks;
  sti_pkg::state_t                  state, state_next;
  sti_pkg::ctrl_t                   ctrl;
  logic                             accept;
  logic                             full;
  logic                             ins;
  logic [sti_pkg::CNT_W-1:0]        count;
  logic [sti_pkg::CNT_W-1:0]        count_next;
  logic [sti_pkg::CNT_W-1:0]        pos;
  logic [sti_pkg::IDX_W-1:0]        pos_enc;
  logic                             rej;
  logic [sti_pkg::IDX_W-1:0]        read_idx;
  logic [sti_pkg::IDX_W-1:0]        last_idx;
  logic [sti_pkg::IDX_W-1:0]        last_idx_next;

  assign accept = start && !ctrl.busy;
  assign full   = (count == sti_pkg::CNT_W'(sti_pkg::DEPTH));
  assign ins    = accept && !full;
  assign busy   = ctrl.busy;

  for (genvar i = 0; i < sti_pkg::DEPTH; i++) begin : g_cell
    sti_pkg::cell_link_t left;
    if (i == 0) begin : g_first
      assign left = BOUNDARY;
    end else begin : g_rest
      assign left = cell_out[i-1];
    end
    sti_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ins       (ins),
      .new_value (new_value),
      .left      (left),
      .link      (cell_out[i]),
      .mark      (marks[i])
    );
  end

  // marks is one-hot on insert, so an OR of indices encodes it.
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < sti_pkg::DEPTH; i++) begin
      if (marks[i]) begin
        pos_enc = pos_enc | sti_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_next = full ? count : count + 1'b1;
    if (count_next > sti_pkg::CNT_W'(sti_pkg::OUT_N)) begin
      last_idx_next = sti_pkg::IDX_W'(sti_pkg::OUT_N - 1);
    end else begin
      last_idx_next = sti_pkg::IDX_W'(count_next - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rej      <= full;
      pos      <= full ? sti_pkg::CNT_W'(sti_pkg::DEPTH) : sti_pkg::CNT_W'(pos_enc);
      last_idx <= last_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sti_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sti_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sti_pkg::ST_READ;
        end
      end
      sti_pkg::ST_READ: begin
        if (read_idx == last_idx) begin
          state_next = sti_pkg::ST_IDLE;
        end
      end
      default: state_next = sti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      sti_pkg::ST_IDLE: ctrl = '0;
      sti_pkg::ST_READ: begin
        ctrl.busy = 1'b1;
        ctrl.load = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_idx <= '0;
    end else if (accept) begin
      read_idx <= '0;
    end else if (ctrl.load) begin
      read_idx <= read_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctrl.load;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_value <= cell_out[read_idx].val;
      entry_index <= sti_pkg::OUT_IDX_W'(read_idx);
      inserted_at <= sti_pkg::OUT_POS_W'(pos);
      rejected    <= rej;
      is_last     <= (read_idx == last_idx);
    end
  end

endmodule

>>> src/sti_checker.sv
`include "assert_macros.svh"

module sti_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 result_strobe,
  input logic [sti_pkg::OUT_POS_W-1:0]        inserted_at,
  input logic                                 rejected,
  input logic                                 is_last
);

  `CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not start readout")
  `CHK_NEXT(a_readout_runs, result_strobe && !is_last, result_strobe, "gap in readout")
  `CHK_NEXT(a_last_ends, result_strobe && is_last && !start, !result_strobe, "strobe after last")
  `CHK_SAME(a_busy_mid, result_strobe && !is_last, busy, "idle during readout")
  `CHK_NEXT(a_tags_stable, result_strobe && !is_last,
            $stable(inserted_at) && $stable(rejected), "tags changed in readout")

endmodule

bind sorted_table_insert sti_checker u_sti_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .inserted_at   (inserted_at),
  .rejected      (rejected),
  .is_last       (is_last)
);

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS   = 480;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 2 * sti_pkg::OUT_N + 8;
  localparam int MAX_PRINTS  = 20;

  typedef struct {
    logic signed [sti_pkg::VAL_W-1:0]     value;
    logic        [sti_pkg::OUT_IDX_W-1:0] index;
    logic        [sti_pkg::OUT_POS_W-1:0] pos;
    logic                                 rej;
    logic                                 last;
  } readout_row_t;

  // Holds a copy of the sorted table and the readout rows still owed by the block.
  class table_scoreboard;
    logic signed [sti_pkg::VAL_W-1:0] rows[sti_pkg::DEPTH];
    int                               fill;
    readout_row_t                     owed[$];
    int                               errors;
    int                               inserts;
    int                               drops;
    int                               checked;

    function void clear();
      fill    = 0;
      errors  = 0;
      inserts = 0;
      drops   = 0;
      checked = 0;
      owed.delete();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // Apply one insert to the local table and queue the full readout it causes.
    function void note_insert(input logic signed [sti_pkg::VAL_W-1:0] v);
      int           pos;
      int           n;
      bit           found;
      logic         rej;
      readout_row_t r;
      if (fill >= sti_pkg::DEPTH) begin
        rej = 1'b1;
        pos = sti_pkg::DEPTH;
        drops++;
      end else begin
        rej   = 1'b0;
        pos   = fill;
        found = 0;
        for (int i = 0; i < fill; i++) begin
          if (!found && v < rows[i]) begin
            pos   = i;
            found = 1;
          end
        end
        for (int i = fill; i > pos; i--)
          rows[i] = rows[i-1];
        rows[pos] = v;
        fill++;
        inserts++;
      end
      n = (fill > sti_pkg::MAX_OUT) ? sti_pkg::MAX_OUT : fill;
      for (int i = 0; i < n; i++) begin
        r.value = rows[i];
        r.index = sti_pkg::OUT_IDX_W'(i);
        r.pos   = sti_pkg::OUT_POS_W'(pos);
        r.rej   = rej;
        r.last  = (i + 1 == n);
        owed.push_back(r);
      end
    endfunction

    task check_result(input readout_row_t got);
      readout_row_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result value=%0d index=%0d", got.value, got.index));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.value !== want.value)
        report($sformatf("entry_value %0d, expected %0d (index %0d)",
                         got.value, want.value, want.index));
      if (got.index !== want.index)
        report($sformatf("entry_index %0d, expected %0d", got.index, want.index));
      if (got.pos !== want.pos)
        report($sformatf("inserted_at %0d, expected %0d", got.pos, want.pos));
      if (got.rej !== want.rej)
        report($sformatf("rejected %b, expected %b", got.rej, want.rej));
      if (got.last !== want.last)
        report($sformatf("is_last %b, expected %b (index %0d)",
                         got.last, want.last, want.index));
    endtask
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic signed [sti_pkg::VAL_W-1:0]     new_value;
  logic                                 result_strobe;
  logic signed [sti_pkg::VAL_W-1:0]     entry_value;
  logic        [sti_pkg::OUT_IDX_W-1:0] entry_index;
  logic        [sti_pkg::OUT_POS_W-1:0] inserted_at;
  logic                                 rejected;
  logic                                 is_last;

  table_scoreboard sb;
  int              cycles;

  sorted_table_insert DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .new_value     (new_value),
    .result_strobe (result_strobe),
    .entry_value   (entry_value),
    .entry_index   (entry_index),
    .inserted_at   (inserted_at),
    .rejected      (rejected),
    .is_last       (is_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sorted_table_insert: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    readout_row_t got;
    if (!rst && result_strobe === 1'b1) begin
      got.value = entry_value;
      got.index = entry_index;
      got.pos   = inserted_at;
      got.rej   = rejected;
      got.last  = is_last;
      sb.check_result(got);
    end
  end

  // Extremes, equal values and alternating bit patterns first.
  logic signed [sti_pkg::VAL_W-1:0] directed_vals[16] = '{
    32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1,
    32'sd1,         32'sh0000_0000, 32'sh0000_0000, 32'sh7FFF_FFFF,
    32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100,
    -32'sd100,      32'sd100,       32'sd50,        -32'sd1
  };

  function automatic logic signed [sti_pkg::VAL_W-1:0] pick_value(input int k);
    logic signed [sti_pkg::VAL_W-1:0] v;
    if (k < 16)
      return directed_vals[k];
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0000_0000;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(0, 16)) - 32'sd8;  // dense, gives duplicates
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Holds start until the transfer happens; start stays high if the caller
  // pushes again right away.
  task push_value(input logic signed [sti_pkg::VAL_W-1:0] v);
    @(negedge clk);
    start     <= 1'b1;
    new_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_insert(v);
  endtask

  task idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    sb = new();
    sb.clear();
    cycles    = 0;
    rst       = 1'b1;
    start     = 1'b0;
    new_value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sent = 0;
    while (sent < NUM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < NUM_ITEMS; b++) begin
        push_value(pick_value(sent));
        sent++;
      end
      // gaps of up to a whole readout land start on every phase of the block
      case ($urandom_range(0, 3))
        0: ;
        1: idle_cycles($urandom_range(1, 4));
        default: idle_cycles($urandom_range(1, 40));
      endcase
    end
    idle_cycles(1);

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d values stored, %0d dropped on a full table, %0d readout rows compared",
             sb.inserts, sb.drops, sb.checked);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0)
      $display("** sorted_table_insert: PASSED **");
    else
      $display("** sorted_table_insert: FAILED **");
    $finish;
  end

endmodule
